[design/tcf_pkg.sv]
// Shared constants and helpers for the Toeplitz Cholesky factor core.
package tcf_pkg;
  localparam int unsigned MaxDim    = 10;
  localparam int unsigned ValW      = 18;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned AccW      = 64;
  localparam int unsigned TriDepth  = MaxDim * (MaxDim + 1) / 2;
  localparam int unsigned TriW      = $clog2(TriDepth);
  localparam int unsigned DefDim    = 10;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [AccW-1:0] acc_t;

  // datapath command from controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INIT,     // load acc from coeff[r-c]
    CMD_MAC,      // acc -= a*b (operands read last cycle)
    CMD_DIV,      // start divide acc / diag
    CMD_SQRT,     // start sqrt acc
    CMD_ZERO      // result = 0
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] k;
    logic            rd;    // issue factor reads for (row,k) and (col,k)
    logic            wr;    // store result at (row,col)
  } dp_cmd_t;

  typedef struct packed {
    logic busy;       // divider/sqrt unit running
    logic res_vld;    // result ready this cycle
    logic acc_pos;    // acc > 0
    logic diag_pos;   // stored diagonal > 0
  } dp_sts_t;

  function automatic logic [TriW-1:0] tri_at(input logic [IdxW-1:0] r,
                                            input logic [IdxW-1:0] c);
    logic [TriW+IdxW-1:0] t;
    t = (TriW+IdxW)'(r) * (TriW+IdxW)'(r + 1'b1);
    return TriW'((t >> 1) + (TriW+IdxW)'(c));
  endfunction
endpackage

[design/tcf_datapath.sv]
// Datapath: coefficient and factor memories, MAC, iterative divide/sqrt.
module tcf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_en,
  input  logic [tcf_pkg::IdxW-1:0] ld_idx,
  input  tcf_pkg::val_t       ld_val,
  input  tcf_pkg::dp_cmd_t    cmd,
  output tcf_pkg::dp_sts_t    sts,
  output tcf_pkg::val_t       res
);
  import tcf_pkg::*;

  val_t coeff_mem [MaxDim];
  val_t fac_mem   [TriDepth];
  val_t rda_r, rdb_r, diag_r, coef_r;
  acc_t acc_r, acc_nxt;
  val_t res_r, res_nxt;

  // shared shift-subtract unit
  logic [AccW-1:0] rem_r, rem_nxt;
  logic [AccW-1:0] quo_r, quo_nxt;   // quotient / sqrt root
  logic [AccW-1:0] num_r, num_nxt;   // dividend shifting out / sqrt bit
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, sqrt_r, sqrt_nxt, neg_r, neg_nxt;
  logic            done_r, done_nxt;
  logic [ValW-1:0] dabs;
  logic [TriW-1:0] addr_b;

  // port b serves the (col,k) operand on reads, the diagonal otherwise
  assign addr_b = cmd.rd ? tri_at(cmd.col, cmd.k) : tri_at(cmd.col, cmd.col);

  always_ff @(posedge clk) begin
    if (ld_en) coeff_mem[ld_idx] <= ld_val;
    coef_r <= coeff_mem[IdxW'(cmd.row - cmd.col)];
    if (cmd.wr) fac_mem[tri_at(cmd.row, cmd.col)] <= res_r;
    if (cmd.rd) begin
      rda_r <= fac_mem[tri_at(cmd.row, cmd.k)];
      rdb_r <= fac_mem[addr_b];
    end else begin
      diag_r <= fac_mem[addr_b];
    end
  end

  assign dabs = diag_r[ValW-1] ? ValW'(-diag_r) : diag_r;

  always_comb begin
    logic [AccW-1:0] tr;
    logic [AccW:0]   df;
    logic signed [AccW-1:0] q;
    logic signed [2*ValW-1:0] prod;
    acc_nxt = acc_r;  res_nxt = res_r;
    rem_nxt = rem_r;  quo_nxt = quo_r; num_nxt = num_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; sqrt_nxt = sqrt_r; neg_nxt = neg_r; done_nxt = 1'b0;
    tr = '0; df = '0; q = '0;
    prod = rda_r * rdb_r;
    unique case (cmd.op)
      CMD_INIT: acc_nxt = acc_t'(coef_r) <<< 16;
      CMD_MAC:  acc_nxt = acc_r - acc_t'(prod);
      CMD_ZERO: begin res_nxt = '0; done_nxt = 1'b1; end
      CMD_DIV: begin
        busy_nxt = 1'b1; sqrt_nxt = 1'b0; cnt_nxt = 7'd64;
        neg_nxt = acc_r[AccW-1];
        num_nxt = acc_r[AccW-1] ? AccW'(-acc_r) : acc_r;
        rem_nxt = '0; quo_nxt = '0;
      end
      CMD_SQRT: begin
        busy_nxt = 1'b1; sqrt_nxt = 1'b1; cnt_nxt = 7'd32;
        rem_nxt = acc_r; quo_nxt = '0; num_nxt = AccW'(1) << 62;
      end
      default: ;
    endcase
    if (busy_r) begin
      if (!sqrt_r) begin
        tr = {rem_r[AccW-2:0], num_r[AccW-1]};
        num_nxt = num_r << 1;
        df = {1'b0, tr} - (AccW+1)'(dabs);
        if (!df[AccW]) begin rem_nxt = df[AccW-1:0]; quo_nxt = {quo_r[AccW-2:0], 1'b1}; end
        else begin rem_nxt = tr; quo_nxt = {quo_r[AccW-2:0], 1'b0}; end
      end else begin
        df = {1'b0, rem_r} - {1'b0, quo_r + num_r};
        if (!df[AccW]) begin
          rem_nxt = df[AccW-1:0]; quo_nxt = (quo_r >> 1) + num_r;
        end else quo_nxt = quo_r >> 1;
        num_nxt = num_r >> 2;
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin busy_nxt = 1'b0; done_nxt = 1'b1; end
    end
    if (done_r) begin
      q = neg_r && !sqrt_r ? AccW'(-quo_r) : quo_r;
      if (q > 131071) res_nxt = val_t'(18'sh1FFFF);
      else if (q < -131072) res_nxt = val_t'(18'sh20000);
      else res_nxt = q[ValW-1:0];
    end
  end

  logic rv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt && cmd.op != CMD_ZERO;
      rv_r <= (done_r) || (cmd.op == CMD_ZERO);
    end
    acc_r <= acc_nxt; res_r <= res_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    num_r <= num_nxt; cnt_r <= cnt_nxt; sqrt_r <= sqrt_nxt; neg_r <= neg_nxt;
  end

  assign sts.busy     = busy_r || done_r;
  assign sts.res_vld  = rv_r;
  assign sts.acc_pos  = !acc_r[AccW-1] && (acc_r != '0);
  assign sts.diag_pos = !diag_r[ValW-1] && (diag_r != '0);
  assign res = res_r;

  a_busy_nodone: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !rv_r) else $error("result during iteration");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> rv_r) else $error("lost result");
  a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && sqrt_r) |-> cnt_r <= 7'd32) else $error("sqrt count");
endmodule

[design/tcf_ctrl.sv]
// Controller: load counting and per-entry sequencing of the factorization.
module tcf_ctrl #(
  parameter int unsigned MATRIX_SIZE = tcf_pkg::DefDim
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               ld_en,
  output logic [tcf_pkg::IdxW-1:0] ld_idx,
  output tcf_pkg::dp_cmd_t   cmd,
  input  tcf_pkg::dp_sts_t   sts,
  output logic               o_valid,
  input  logic               o_ready,
  output logic [tcf_pkg::IdxW-1:0] o_row,
  output logic [tcf_pkg::IdxW-1:0] o_col,
  output logic               o_err,
  output logic               o_last
);
  import tcf_pkg::*;

  localparam logic [IdxW-1:0] DimM1 = IdxW'(MATRIX_SIZE - 1);

  typedef enum logic [3:0] {
    S_LOAD, S_PRE, S_INIT, S_RD, S_MAC, S_CHK, S_WAIT, S_WR, S_EMIT
  } st_t;

  st_t st_r;
  logic [IdxW-1:0] cnt_r, r_r, c_r, k_r;
  logic err_r, ov_r;

  wire take = in_valid && in_ready;
  assign in_ready = (st_r == S_LOAD);
  assign ld_en  = take && (cnt_r <= DimM1);
  assign ld_idx = cnt_r;

  always_comb begin
    cmd = '{op: CMD_NONE, row: r_r, col: c_r, k: k_r, rd: 1'b0, wr: 1'b0};
    unique case (st_r)
      S_INIT: cmd.op = err_r ? CMD_ZERO : CMD_INIT;
      S_RD:   cmd.rd = 1'b1;
      S_MAC:  cmd.op = CMD_MAC;
      S_CHK: begin
        if (c_r != r_r) cmd.op = sts.diag_pos ? CMD_DIV : CMD_ZERO;
        else cmd.op = sts.acc_pos ? CMD_SQRT : CMD_ZERO;
      end
      S_WR:   cmd.wr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; err_r <= 1'b0; ov_r <= 1'b0;
      r_r <= '0; c_r <= '0; k_r <= '0;
    end else begin
      unique case (st_r)
        S_LOAD: if (take) begin
          if (cnt_r <= DimM1) cnt_r <= cnt_r + 1'b1;
          if (in_last) begin
            st_r <= S_PRE; err_r <= 1'b0; r_r <= '0; c_r <= '0; k_r <= '0;
          end
        end
        // coefficient for lag row-col is fetched into the datapath here
        S_PRE: st_r <= S_INIT;
        S_INIT: begin
          k_r <= '0;
          if (err_r) st_r <= S_WAIT;
          else if (c_r == '0) st_r <= S_CHK;
          else st_r <= S_RD;
        end
        S_RD:  st_r <= S_MAC;
        S_MAC: begin
          if (k_r + 1'b1 == c_r) st_r <= S_CHK;
          else begin k_r <= k_r + 1'b1; st_r <= S_RD; end
        end
        S_CHK: begin
          if (c_r == r_r && !sts.acc_pos) err_r <= 1'b1;
          st_r <= S_WAIT;
        end
        S_WAIT: if (sts.res_vld) st_r <= S_WR;
        S_WR:   begin ov_r <= 1'b1; st_r <= S_EMIT; end
        S_EMIT: if (o_ready) begin
          ov_r <= 1'b0;
          if (c_r == r_r) begin
            if (r_r == DimM1) begin st_r <= S_LOAD; cnt_r <= '0; end
            else begin r_r <= r_r + 1'b1; c_r <= '0; st_r <= S_PRE; end
          end else begin c_r <= c_r + 1'b1; st_r <= S_PRE; end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign o_valid = ov_r && (st_r == S_EMIT);
  assign o_row = r_r;
  assign o_col = c_r;
  assign o_err = err_r;
  assign o_last = (r_r == DimM1) && (c_r == r_r);

  a_col_le_row: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> o_col <= o_row) else $error("col above row");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_LOAD) |-> !ld_en) else $error("load while factoring");
  a_wait_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> !sts.busy) else $error("unit busy at emit");
endmodule

[design/toeplitz_cholesky_factor_core.sv]
// Top level: Toeplitz Cholesky factor core (controller plus datapath).
// Sequencing: each entry runs its MAC steps, then a divide (64 bit-steps in the
//   shared shift-subtract unit) or a square root; entries after a failed
//   radicand skip both, and output stalls hold the sequence.
// Throughput: one coefficient transaction per cycle while loading; none is
//   taken until the last entry is out; the one-bit-per-cycle divider dominates.
// Reset: synchronous active-low; clears controller state, counts and the
//   datapath busy/done flags; coefficient and factor memories are not cleared.
module toeplitz_cholesky_factor_core #(
  parameter int unsigned MATRIX_SIZE = tcf_pkg::DefDim
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcf_pkg::val_t      in_coeff,
  input  logic               in_last_coeff,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [tcf_pkg::IdxW-1:0] out_row_index,
  output logic [tcf_pkg::IdxW-1:0] out_col_index,
  output tcf_pkg::val_t      out_factor_value,
  output logic               out_not_positive,
  output logic               out_last_entry
);
  import tcf_pkg::*;

  logic            ld_en;
  logic [IdxW-1:0] ld_idx;
  dp_cmd_t         cmd;
  dp_sts_t         sts;

  tcf_ctrl #(.MATRIX_SIZE(MATRIX_SIZE)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last(in_last_coeff),
    .ld_en, .ld_idx, .cmd, .sts,
    .o_valid(out_valid), .o_ready(out_ready), .o_row(out_row_index),
    .o_col(out_col_index), .o_err(out_not_positive), .o_last(out_last_entry)
  );

  // result register holds the entry for the whole output transaction
  tcf_datapath u_dp (
    .clk, .rst_n, .ld_en, .ld_idx, .ld_val(in_coeff), .cmd, .sts,
    .res(out_factor_value)
  );
endmodule
